[hdl/cdq_pkg.sv]
// cdq_pkg: sizes, operation and status codes, and controller states for the
// circular deque. No dependencies; used by circular_deque.
package cdq_pkg;

   // capacity must be a power of two: slot arithmetic wraps by truncation
   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int PTR_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);

   localparam int KIND_W   = 3;
   localparam int INDEX_W  = 4;
   localparam int STATUS_W = 2;

   localparam int REQ_DATA_W = 40;  // index + value, padded to bytes
   localparam int RSP_DATA_W = 40;  // result_value + status + count, padded

   localparam logic [KIND_W-1:0] KIND_ADD_HIGH = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ADD_LOW  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_REM_HIGH = 3'd2;
   localparam logic [KIND_W-1:0] KIND_REM_LOW  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_GET      = 3'd4;
   localparam logic [KIND_W-1:0] KIND_PUT      = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_INDEX = 2'd3;

   typedef enum logic [0:0] {
      S_IDLE,
      S_EXEC
   } state_type;

endpackage

[hdl/circular_deque.sv]
// circular_deque: double-ended queue in a one-port-write, one-port-read slot
// memory with head pointer and fill count. Depends on cdq_pkg.
// A result is offered from the output register when S_EXEC finishes its item;
// S_EXEC holds while the previous result still waits in the output register.
// Items are taken one at a time, accepted in S_IDLE and finished in S_EXEC; the
// slot memory read (registered) must land before the read-modify-write step that finishes it.
// A new request is taken while the previous result still waits in the output
// register; it finishes once that register is free.
// Reset (synchronous): head and fill go to zero, slot memory keeps contents.
module circular_deque (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [3:0] index, [35:4] value, [39:36] zero
   input  logic [cdq_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [2:0] kind
   input  logic [cdq_pkg::KIND_W-1:0]       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [31:0] result_value, [33:32] status, [38:34] count, [39] zero
   output logic [cdq_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int PW = cdq_pkg::PTR_W;
   localparam int CW = cdq_pkg::CNT_W;
   localparam int DW = cdq_pkg::DATA_WIDTH;

   cdq_pkg::state_type state_ff, state_in;

   logic [PW-1:0] head_ff, head_in;
   logic [CW-1:0] fill_ff, fill_in;

   logic [cdq_pkg::KIND_W-1:0]  kind_ff;
   logic [cdq_pkg::INDEX_W-1:0] index_ff;
   logic [DW-1:0]               value_ff;
   logic [PW-1:0]               addr_ff;
   logic [PW-1:0]               addr_in;

   logic [DW-1:0] slot_mem [cdq_pkg::DEPTH];
   logic [DW-1:0] rd_data_ff;

   logic                        rsp_valid_ff;
   logic [DW-1:0]               res_value_ff, res_value_in;
   logic [cdq_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [CW-1:0]               res_count_ff;

   logic req_beat;
   logic finish;
   logic wr_en;

   logic [cdq_pkg::KIND_W-1:0]  req_kind;
   logic [cdq_pkg::INDEX_W-1:0] req_index;
   logic [DW-1:0]               req_value;

   assign req_kind  = req_tuser;
   assign req_index = req_tdata[cdq_pkg::INDEX_W-1:0];
   assign req_value = req_tdata[cdq_pkg::INDEX_W +: DW];

   assign req_beat = req_tvalid && req_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cdq_pkg::S_IDLE: begin
            if (req_tvalid) state_in = cdq_pkg::S_EXEC;
         end
         cdq_pkg::S_EXEC: begin
            if (!rsp_valid_ff || rsp_tready) state_in = cdq_pkg::S_IDLE;
         end
         default: state_in = cdq_pkg::S_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      finish     = 1'b0;
      case (state_ff)
         cdq_pkg::S_IDLE: req_tready = !reset;
         cdq_pkg::S_EXEC: finish = !rsp_valid_ff || rsp_tready;
         default: begin
            req_tready = 1'b0;
            finish     = 1'b0;
         end
      endcase
   end

   // slot touched by the operation, from state as it stands at acceptance
   always_comb begin
      case (req_kind)
         cdq_pkg::KIND_ADD_HIGH: addr_in = head_ff + fill_ff[PW-1:0];
         cdq_pkg::KIND_ADD_LOW:  addr_in = head_ff - PW'(1);
         cdq_pkg::KIND_REM_HIGH: addr_in = head_ff + fill_ff[PW-1:0] - PW'(1);
         cdq_pkg::KIND_GET,
         cdq_pkg::KIND_PUT:      addr_in = head_ff + PW'(req_index);
         default:                addr_in = head_ff;
      endcase
   end

   // read-modify-write step
   always_comb begin
      head_in       = head_ff;
      fill_in       = fill_ff;
      res_value_in  = '0;
      res_status_in = cdq_pkg::ST_OK;
      wr_en         = 1'b0;
      case (kind_ff)
         cdq_pkg::KIND_ADD_HIGH: begin
            if (fill_ff == CW'(cdq_pkg::DEPTH)) begin
               res_status_in = cdq_pkg::ST_FULL;
            end else begin
               fill_in      = fill_ff + CW'(1);
               res_value_in = value_ff;
               wr_en        = 1'b1;
            end
         end
         cdq_pkg::KIND_ADD_LOW: begin
            if (fill_ff == CW'(cdq_pkg::DEPTH)) begin
               res_status_in = cdq_pkg::ST_FULL;
            end else begin
               head_in      = addr_ff;
               fill_in      = fill_ff + CW'(1);
               res_value_in = value_ff;
               wr_en        = 1'b1;
            end
         end
         cdq_pkg::KIND_REM_HIGH: begin
            if (fill_ff == '0) begin
               res_status_in = cdq_pkg::ST_EMPTY;
            end else begin
               fill_in      = fill_ff - CW'(1);
               res_value_in = rd_data_ff;
            end
         end
         cdq_pkg::KIND_REM_LOW: begin
            if (fill_ff == '0) begin
               res_status_in = cdq_pkg::ST_EMPTY;
            end else begin
               head_in      = head_ff + PW'(1);
               fill_in      = fill_ff - CW'(1);
               res_value_in = rd_data_ff;
            end
         end
         cdq_pkg::KIND_GET: begin
            if (CW'(index_ff) >= fill_ff) begin
               res_status_in = cdq_pkg::ST_INDEX;
            end else begin
               res_value_in = rd_data_ff;
            end
         end
         cdq_pkg::KIND_PUT: begin
            if (CW'(index_ff) >= fill_ff) begin
               res_status_in = cdq_pkg::ST_INDEX;
            end else begin
               res_value_in = rd_data_ff;
               wr_en        = 1'b1;
            end
         end
         default: begin
            res_status_in = cdq_pkg::ST_OK;
         end
      endcase
      if (!finish) wr_en = 1'b0;
   end

   // slot memory: read on acceptance, write back on finish
   always_ff @(posedge clock) begin
      if (req_beat) rd_data_ff <= slot_mem[addr_in];
      if (wr_en) slot_mem[addr_ff] <= value_ff;
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         kind_ff  <= req_kind;
         index_ff <= req_index;
         value_ff <= req_value;
         addr_ff  <= addr_in;
      end
      if (finish) begin
         res_value_ff  <= res_value_in;
         res_status_ff <= res_status_in;
         res_count_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cdq_pkg::S_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (finish) begin
            head_ff      <= head_in;
            fill_ff      <= fill_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, res_count_ff, res_status_ff, res_value_ff};

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(cdq_pkg::DEPTH))
      else $error("fill count beyond capacity");

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> state_ff == cdq_pkg::S_EXEC)
      else $error("accepted beat did not start execution");

   a_count_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> res_count_ff == fill_ff)
      else $error("offered count differs from fill");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && res_status_ff == cdq_pkg::ST_EMPTY) |-> res_count_ff == '0)
      else $error("empty status with elements held");

   a_write_on_finish: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == cdq_pkg::S_EXEC && res_status_in == cdq_pkg::ST_OK))
      else $error("slot write outside a successful finish");

endmodule

[tb/tb.sv]
// tb: self-checking bench for circular_deque, a directed table and then biased random
// operations, each result checked against a table value or a behavioral deque predictor.
// Depends on cdq_pkg and circular_deque.
`timescale 1ns / 1ps

module tb;

   localparam logic [cdq_pkg::KIND_W-1:0] KIND_NOP6 = 3'd6;
   localparam logic [cdq_pkg::KIND_W-1:0] KIND_NOP7 = 3'd7;
   localparam int RANDOM_ITEMS = 1100;
   localparam int IDLE_PCT     = 27;

   typedef struct packed {
      logic [cdq_pkg::DATA_WIDTH-1:0] value;
      logic [cdq_pkg::STATUS_W-1:0]   status;
      logic [cdq_pkg::CNT_W-1:0]      count;
   } deque_rsp_type;

   typedef struct packed {
      logic [cdq_pkg::KIND_W-1:0]     kind;
      logic [cdq_pkg::INDEX_W-1:0]    index;
      logic [cdq_pkg::DATA_WIDTH-1:0] value;
      bit                             typed;
      deque_rsp_type                  want;
   } stim_row_type;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [cdq_pkg::REQ_DATA_W-1:0] req_tdata;
   logic [cdq_pkg::KIND_W-1:0]     req_tuser;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [cdq_pkg::RSP_DATA_W-1:0] rsp_tdata;

   // predictor state
   logic [cdq_pkg::DATA_WIDTH-1:0] deq_slot [cdq_pkg::DEPTH];
   int                             deq_head;
   int                             deq_fill;

   deque_rsp_type expected_rsp_q [$];
   stim_row_type  stim_table [$];
   int            error_count;
   int            rsp_seen;
   int            backpressure_left;
   bit            backpressure_done;
   bit            calm;

   circular_deque DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic deque_rsp_type mk_rsp(input logic [cdq_pkg::DATA_WIDTH-1:0] value,
                                            input logic [cdq_pkg::STATUS_W-1:0] status,
                                            input int count);
      deque_rsp_type r;
      r.value  = value;
      r.status = status;
      r.count  = count[cdq_pkg::CNT_W-1:0];
      return r;
   endfunction

   task automatic add_row(input logic [cdq_pkg::KIND_W-1:0] kind,
                          input logic [cdq_pkg::INDEX_W-1:0] index,
                          input logic [cdq_pkg::DATA_WIDTH-1:0] value, input bit typed,
                          input deque_rsp_type want);
      stim_row_type row;
      row.kind  = kind;
      row.index = index;
      row.value = value;
      row.typed = typed;
      row.want  = want;
      stim_table.push_back(row);
   endtask

   // one deque operation on the predictor state; logical i sits in slot (head + i) mod DEPTH
   task automatic deque_apply(input logic [cdq_pkg::KIND_W-1:0] kind,
                              input logic [cdq_pkg::INDEX_W-1:0] index,
                              input logic [cdq_pkg::DATA_WIDTH-1:0] value,
                              output deque_rsp_type r);
      int slot;
      r = '0;
      r.status = cdq_pkg::ST_OK;
      case (kind)
         cdq_pkg::KIND_ADD_HIGH, cdq_pkg::KIND_ADD_LOW: begin
            if (deq_fill >= cdq_pkg::DEPTH) begin
               r.status = cdq_pkg::ST_FULL;
            end else begin
               if (kind == cdq_pkg::KIND_ADD_HIGH) begin
                  slot = (deq_head + deq_fill) % cdq_pkg::DEPTH;
               end else begin
                  deq_head = (deq_head + cdq_pkg::DEPTH - 1) % cdq_pkg::DEPTH;
                  slot = deq_head;
               end
               deq_slot[slot] = value;
               deq_fill++;
               r.value = value;
            end
         end
         cdq_pkg::KIND_REM_HIGH: begin
            if (deq_fill == 0) begin
               r.status = cdq_pkg::ST_EMPTY;
            end else begin
               deq_fill--;
               r.value = deq_slot[(deq_head + deq_fill) % cdq_pkg::DEPTH];
            end
         end
         cdq_pkg::KIND_REM_LOW: begin
            if (deq_fill == 0) begin
               r.status = cdq_pkg::ST_EMPTY;
            end else begin
               r.value = deq_slot[deq_head];
               deq_head = (deq_head + 1) % cdq_pkg::DEPTH;
               deq_fill--;
            end
         end
         cdq_pkg::KIND_GET, cdq_pkg::KIND_PUT: begin
            if (int'(index) >= deq_fill) begin
               r.status = cdq_pkg::ST_INDEX;
            end else begin
               slot = (deq_head + int'(index)) % cdq_pkg::DEPTH;
               r.value = deq_slot[slot];
               if (kind == cdq_pkg::KIND_PUT) deq_slot[slot] = value;
            end
         end
         default: ;
      endcase
      r.count = deq_fill[cdq_pkg::CNT_W-1:0];
   endtask

   // called at a falling edge, returns at the falling edge after the beat
   task automatic send_item(input logic [cdq_pkg::KIND_W-1:0] kind,
                            input logic [cdq_pkg::INDEX_W-1:0] index,
                            input logic [cdq_pkg::DATA_WIDTH-1:0] value, input bit typed,
                            input deque_rsp_type want);
      deque_rsp_type predicted;
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0, value, index};
      do @(posedge clock); while (!req_tready);
      deque_apply(kind, index, value, predicted);
      expected_rsp_q.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   task automatic drain_wait();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (expected_rsp_q.size() != 0);
   endtask

   // random operation biased by a grow or shrink trend so full and empty are both reached
   task automatic send_random(input bit grow);
      logic [cdq_pkg::KIND_W-1:0]     kind;
      logic [cdq_pkg::INDEX_W-1:0]    index;
      logic [cdq_pkg::DATA_WIDTH-1:0] value;
      int                             pick;
      pick = $urandom_range(99);
      if (pick < 3)
         kind = $urandom_range(1) ? KIND_NOP6 : KIND_NOP7;
      else if (pick < 48)
         kind = grow ? ($urandom_range(1) ? cdq_pkg::KIND_ADD_HIGH : cdq_pkg::KIND_ADD_LOW)
                     : ($urandom_range(1) ? cdq_pkg::KIND_REM_HIGH : cdq_pkg::KIND_REM_LOW);
      else if (pick < 63)
         kind = grow ? ($urandom_range(1) ? cdq_pkg::KIND_REM_HIGH : cdq_pkg::KIND_REM_LOW)
                     : ($urandom_range(1) ? cdq_pkg::KIND_ADD_HIGH : cdq_pkg::KIND_ADD_LOW);
      else if (pick < 82)
         kind = cdq_pkg::KIND_GET;
      else
         kind = cdq_pkg::KIND_PUT;
      if (deq_fill > 0 && $urandom_range(99) < 85)
         index = cdq_pkg::INDEX_W'($urandom_range(deq_fill - 1));
      else
         index = cdq_pkg::INDEX_W'($urandom_range(15));
      case ($urandom_range(9))
         0:       value = '0;
         1:       value = '1;
         default: value = $urandom;
      endcase
      send_item(kind, index, value, 1'b0, '0);
   endtask

   // result check, one beat per rising edge
   always @(posedge clock) begin
      deque_rsp_type got;
      deque_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.value  = rsp_tdata[31:0];
         got.status = rsp_tdata[33:32];
         got.count  = rsp_tdata[38:34];
         rsp_seen++;
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: unexpected result beat value=%h status=%0d count=%0d",
                     $time, got.value, got.status, got.count);
            error_count++;
         end else begin
            want = expected_rsp_q.pop_front();
            if (got.value !== want.value) begin
               $display("%0t: value expected %h actual %h", $time, want.value, got.value);
               error_count++;
            end
            if (got.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        got.status);
               error_count++;
            end
            if (got.count !== want.count) begin
               $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
               error_count++;
            end
         end
      end
   end

   // result side ready, dropped at random outside the calm window, with one long hold-off once traffic is flowing
   initial begin
      forever begin
         @(negedge clock);
         if (backpressure_left > 0) begin
            rsp_tready <= 1'b0;
            backpressure_left--;
         end else if (!backpressure_done && rsp_seen >= 300) begin
            backpressure_done = 1'b1;
            backpressure_left = 80;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("tb: errors");
      $finish;
   end

   initial begin
      bit grow;
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      error_count = 0;
      rsp_seen = 0;
      backpressure_left = 0;
      backpressure_done = 1'b0;
      calm = 1'b0;
      deq_head = 0;
      deq_fill = 0;
      for (int k = 0; k < cdq_pkg::DEPTH; k++) deq_slot[k] = '0;

      // errors on an empty deque, the unused kinds (status ok), then one add at each end
      add_row(cdq_pkg::KIND_REM_HIGH, 4'd0,  '0, 1'b1, mk_rsp('0, cdq_pkg::ST_EMPTY, 0));
      add_row(cdq_pkg::KIND_REM_LOW,  4'd0,  '0, 1'b1, mk_rsp('0, cdq_pkg::ST_EMPTY, 0));
      add_row(cdq_pkg::KIND_GET,      4'd0,  '0, 1'b1, mk_rsp('0, cdq_pkg::ST_INDEX, 0));
      add_row(cdq_pkg::KIND_PUT,      4'd15, '1, 1'b1, mk_rsp('0, cdq_pkg::ST_INDEX, 0));
      add_row(KIND_NOP6,              4'd15, '1, 1'b1, mk_rsp('0, cdq_pkg::ST_OK, 0));
      add_row(KIND_NOP7,              4'd0,  '0, 1'b1, mk_rsp('0, cdq_pkg::ST_OK, 0));
      add_row(cdq_pkg::KIND_ADD_HIGH, 4'd0,  '1, 1'b1, mk_rsp('1, cdq_pkg::ST_OK, 1));
      add_row(cdq_pkg::KIND_ADD_LOW,  4'd15, '0, 1'b1, mk_rsp('0, cdq_pkg::ST_OK, 2));
      // put returns the element it replaces
      add_row(cdq_pkg::KIND_PUT,      4'd1,  32'h5a5a_5a5a, 1'b1,
              mk_rsp('1, cdq_pkg::ST_OK, 2));
      add_row(cdq_pkg::KIND_GET,      4'd2,  '0, 1'b1, mk_rsp('0, cdq_pkg::ST_INDEX, 2));
      add_row(cdq_pkg::KIND_REM_HIGH, 4'd0,  '0, 1'b0, '0);
      // fill to capacity from both ends, then one add too many is refused as full
      for (int k = 0; k < cdq_pkg::DEPTH - 1; k++)
         add_row((k % 2) ? cdq_pkg::KIND_ADD_LOW : cdq_pkg::KIND_ADD_HIGH, 4'd0, $urandom,
                 1'b0, '0);
      add_row(cdq_pkg::KIND_ADD_HIGH, 4'd0,  '1, 1'b1,
              mk_rsp('0, cdq_pkg::ST_FULL, cdq_pkg::DEPTH));
      add_row(cdq_pkg::KIND_GET,      4'd15, '0, 1'b0, '0);
      add_row(cdq_pkg::KIND_REM_LOW,  4'd0,  '0, 1'b0, '0);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_table[r])
         send_item(stim_table[r].kind, stim_table[r].index, stim_table[r].value,
                   stim_table[r].typed, stim_table[r].want);
      drain_wait();

      grow = 1'b1;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 48 == 47) grow = ~grow;
         if (i == 550) drain_wait();
         calm = (i >= 700 && i < 900);
         send_random(grow);
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      while (expected_rsp_q.size() != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
